// ===== design/ntt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_pkg
// Types, codes and defaults shared by the nearest target tracker modules.
// ----------------------------------------------------------------------------
package ntt_pkg;

	localparam int MAX_DETECTIONS_DEF        = 32;
	localparam int TICK_SEARCH_RADIUS_MM_DEF = 100000;
	localparam int QUEUE_DEPTH               = 2;
	localparam int D2_W                      = 42;

	localparam logic [1:0] ACT_VEHICLE = 2'd0;
	localparam logic [1:0] ACT_DETECT  = 2'd1;
	localparam logic [1:0] ACT_TICK    = 2'd2;

	localparam logic [1:0] STATUS_CAPTURED = 2'd0;
	localparam logic [1:0] STATUS_LOST     = 2'd1;
	localparam logic [1:0] STATUS_APPROX   = 2'd2;

	localparam logic [2:0] REG_STANDOFF_MM    = 3'd0;
	localparam logic [2:0] REG_CAPTURE_MARGIN = 3'd1;
	localparam logic [2:0] REG_ID_RADIUS      = 3'd2;
	localparam logic [2:0] REG_SENSING_RADIUS = 3'd3;
	localparam logic [2:0] REG_BALL_X         = 3'd4;
	localparam logic [2:0] REG_BALL_Y         = 3'd5;
	localparam logic [2:0] REG_BALL_Z         = 3'd6;
	localparam logic [2:0] REG_LOST_TICKS     = 3'd7;

	typedef struct packed {
		logic        [1:0]  action;
		logic signed [19:0] pos_x;
		logic signed [19:0] pos_y;
		logic signed [19:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic               frame_last;
	} in_item_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [19:0] center_x;
		logic signed [19:0] center_y;
		logic signed [19:0] center_z;
		logic signed [15:0] out_norm_x;
		logic signed [15:0] out_norm_y;
		logic signed [15:0] out_norm_z;
		logic        [18:0] standoff;
	} out_item_t;

	typedef struct packed {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [19:0] z;
	} vec3_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} nvec3_t;

	typedef struct packed {
		vec3_t  pos;
		nvec3_t nrm;
	} det_t;

	typedef struct packed {
		logic            valid;
		logic [D2_W-1:0] d2;
		det_t            det;
	} cand_t;

	typedef struct packed {
		logic        [18:0] standoff_mm;
		logic        [18:0] capture_margin;
		logic        [18:0] id_radius;
		logic        [18:0] sensing_radius;
		vec3_t              ball;
		logic        [15:0] lost_ticks;
	} cfg_t;

endpackage

// ===== design/ntt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ntt_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/ntt_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_fifo
// Small register queue that decouples the accepting side from the engine.
// ----------------------------------------------------------------------------
module ntt_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== design/ntt_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_dist
// Two-stage squared Euclidean distance unit: squares, then their sum.
// ----------------------------------------------------------------------------
module ntt_dist
	import ntt_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  vec3_t           a,
	input  vec3_t           b,
	output logic            done,
	output logic [D2_W-1:0] d2
);

	logic signed [20:0] dx, dy, dz;
	logic signed [41:0] px, py, pz;
	logic [39:0]        sqx_s1, sqy_s1, sqz_s1;
	logic               v_s1, v_s2;

	assign dx = 21'(a.x) - 21'(b.x);
	assign dy = 21'(a.y) - 21'(b.y);
	assign dz = 21'(a.z) - 21'(b.z);
	assign px = dx * dx;
	assign py = dy * dy;
	assign pz = dz * dz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s1 <= px[39:0];
		sqy_s1 <= py[39:0];
		sqz_s1 <= pz[39:0];
		d2     <= D2_W'(sqx_s1) + D2_W'(sqy_s1) + D2_W'(sqz_s1);
	end

	assign done = v_s2;

endmodule

// ===== design/ntt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_back
// Tracking engine: scores detections, closes frames, walks the frame store
// on search ticks and issues reports into the result queue.
// ----------------------------------------------------------------------------
module ntt_back
	import ntt_pkg::*;
#(
	parameter int MAX_DETECTIONS        = MAX_DETECTIONS_DEF,
	parameter int TICK_SEARCH_RADIUS_MM = TICK_SEARCH_RADIUS_MM_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  in_item_t  q_head,
	input  logic      q_empty,
	output logic      q_pop,
	output out_item_t res,
	input  logic      out_full,
	output logic      out_push
);

	localparam int AW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
	localparam int CW = $clog2(MAX_DETECTIONS + 1);
	localparam logic [D2_W-1:0] TICK_R2 =
		D2_W'(longint'(TICK_SEARCH_RADIUS_MM) * longint'(TICK_SEARCH_RADIUS_MM));

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DISPATCH  = 4'd1;
	localparam logic [3:0] S_DVEH      = 4'd2;
	localparam logic [3:0] S_DTGT      = 4'd3;
	localparam logic [3:0] S_ENDF      = 4'd4;
	localparam logic [3:0] S_BALL_END  = 4'd5;
	localparam logic [3:0] S_WALK_RD   = 4'd6;
	localparam logic [3:0] S_WALK_DIST = 4'd7;
	localparam logic [3:0] S_WALK_WAIT = 4'd8;
	localparam logic [3:0] S_TICK_DONE = 4'd9;
	localparam logic [3:0] S_BALL_TICK = 4'd10;
	localparam logic [3:0] S_EMIT      = 4'd11;

	logic [3:0]      state_q;
	in_item_t        item_q;
	det_t            item_det;
	vec3_t           veh_q, tgt_pos_q;
	nvec3_t          tgt_dir_q;
	logic            track_q, tv_q, frame_open_q;
	logic [15:0]     ticks_q, ticks_n;
	cand_t           c0_q, c1_q, c2_q;
	logic [CW-1:0]   fc_q, fc_eff, idx_q;
	logic [39:0]     cap2_q;
	logic [37:0]     id2_q, sr2_q;
	logic [19:0]     cap;
	out_item_t       res_q;

	logic            ram_we, ram_re;
	det_t            ram_rd;
	logic            dist_start, dist_done;
	vec3_t           dist_a, dist_b;
	logic [D2_W-1:0] d2;

	assign item_det = '{pos: '{x: item_q.pos_x, y: item_q.pos_y, z: item_q.pos_z},
		nrm: '{x: item_q.norm_x, y: item_q.norm_y, z: item_q.norm_z}};
	assign fc_eff  = frame_open_q ? fc_q : '0;
	assign ticks_n = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
	assign cap     = 20'(cfg.standoff_mm) + 20'(cfg.capture_margin);
	assign res     = res_q;

	always_ff @(posedge clk) begin
		cap2_q <= cap * cap;
		id2_q  <= cfg.id_radius * cfg.id_radius;
		sr2_q  <= cfg.sensing_radius * cfg.sensing_radius;
	end

	ntt_ram #(.W($bits(det_t)), .DEPTH(MAX_DETECTIONS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fc_eff[AW-1:0]),
		.wdata (item_det),
		.re    (ram_re),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rd)
	);

	ntt_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.a      (dist_a),
		.b      (dist_b),
		.done   (dist_done),
		.d2     (d2)
	);

	always_comb begin
		q_pop      = (state_q == S_IDLE) && !q_empty;
		out_push   = (state_q == S_EMIT) && !out_full;
		ram_we     = (state_q == S_DISPATCH) && (item_q.action == ACT_DETECT)
			&& (fc_eff < CW'(MAX_DETECTIONS));
		ram_re     = (state_q == S_WALK_RD) && (idx_q < fc_q);
		dist_start = 1'b0;
		dist_a     = item_det.pos;
		dist_b     = veh_q;
		unique case (state_q)
			S_DISPATCH: begin
				dist_start = (item_q.action == ACT_DETECT);
			end
			S_DVEH: begin
				dist_start = dist_done;
				dist_b     = tgt_pos_q;
			end
			S_ENDF: begin
				dist_start = !track_q && c0_q.valid && (c0_q.d2 < D2_W'(cap2_q));
				dist_a     = c0_q.det.pos;
				dist_b     = cfg.ball;
			end
			S_WALK_DIST: begin
				dist_start = 1'b1;
				dist_a     = ram_rd.pos;
			end
			S_TICK_DONE: begin
				dist_start = c2_q.valid && (c2_q.d2 < TICK_R2);
				dist_a     = c2_q.det.pos;
				dist_b     = cfg.ball;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			veh_q        <= '0;
			tgt_pos_q    <= '0;
			tgt_dir_q    <= '0;
			track_q      <= 1'b0;
			tv_q         <= 1'b0;
			frame_open_q <= 1'b0;
			ticks_q      <= '0;
			c0_q         <= '0;
			c1_q         <= '0;
			c2_q         <= '0;
			fc_q         <= '0;
			idx_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					state_q <= S_IDLE;
					unique case (item_q.action)
						ACT_VEHICLE: begin
							veh_q <= item_det.pos;
						end
						ACT_DETECT: begin
							if (!frame_open_q) begin
								c0_q.valid   <= 1'b0;
								c1_q.valid   <= 1'b0;
								frame_open_q <= 1'b1;
							end
							fc_q    <= ram_we ? fc_eff + 1'b1 : fc_eff;
							state_q <= S_DVEH;
						end
						ACT_TICK: begin
							if (track_q) begin
								ticks_q <= ticks_n;
								if (ticks_n > cfg.lost_ticks) begin
									track_q <= 1'b0;
									state_q <= S_EMIT;
								end else if (!tv_q) begin
									track_q <= 1'b0;
								end else begin
									state_q <= S_EMIT;
								end
							end else begin
								c2_q.valid <= 1'b0;
								idx_q      <= '0;
								state_q    <= S_WALK_RD;
							end
						end
						default: begin
						end
					endcase
				end
				S_DVEH: begin
					if (dist_done) begin
						if (!c0_q.valid || d2 < c0_q.d2) begin
							c0_q <= '{valid: 1'b1, d2: d2, det: item_det};
						end
						state_q <= S_DTGT;
					end
				end
				S_DTGT: begin
					if (dist_done) begin
						if (!c1_q.valid || d2 < c1_q.d2) begin
							c1_q <= '{valid: 1'b1, d2: d2, det: item_det};
						end
						state_q <= item_q.frame_last ? S_ENDF : S_IDLE;
					end
				end
				S_ENDF: begin
					frame_open_q <= 1'b0;
					state_q      <= S_IDLE;
					if (!track_q) begin
						if (dist_start) begin
							tgt_pos_q <= c0_q.det.pos;
							tgt_dir_q <= c0_q.det.nrm;
							tv_q      <= 1'b1;
							ticks_q   <= '0;
							state_q   <= S_BALL_END;
						end else begin
							tv_q <= 1'b0;
						end
					end else if (!tv_q) begin
						track_q <= 1'b0;
					end else if (c1_q.valid && c1_q.d2 < D2_W'(id2_q)) begin
						tgt_pos_q <= c1_q.det.pos;
						tgt_dir_q <= c1_q.det.nrm;
						ticks_q   <= '0;
					end
				end
				S_BALL_END: begin
					if (dist_done) begin
						if (d2 < D2_W'(sr2_q)) begin
							track_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_WALK_RD: begin
					state_q <= ram_re ? S_WALK_DIST : S_TICK_DONE;
				end
				S_WALK_DIST: begin
					state_q <= S_WALK_WAIT;
				end
				S_WALK_WAIT: begin
					if (dist_done) begin
						if (!c2_q.valid || d2 < c2_q.d2) begin
							c2_q <= '{valid: 1'b1, d2: d2, det: ram_rd};
						end
						idx_q   <= idx_q + 1'b1;
						state_q <= S_WALK_RD;
					end
				end
				S_TICK_DONE: begin
					if (dist_start) begin
						ticks_q <= '0;
						state_q <= S_BALL_TICK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_BALL_TICK: begin
					if (dist_done) begin
						state_q <= (d2 < D2_W'(sr2_q)) ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					if (!out_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_head;
		end
		if (state_q == S_DISPATCH && item_q.action == ACT_TICK && track_q) begin
			if (ticks_n > cfg.lost_ticks) begin
				res_q <= '{status: STATUS_LOST, standoff: '0, default: '0};
			end else begin
				res_q <= '{status: STATUS_CAPTURED,
					center_x: tgt_pos_q.x, center_y: tgt_pos_q.y, center_z: tgt_pos_q.z,
					out_norm_x: tgt_dir_q.x, out_norm_y: tgt_dir_q.y,
					out_norm_z: tgt_dir_q.z, standoff: cfg.standoff_mm};
			end
		end else if (state_q == S_BALL_TICK) begin
			res_q <= '{status: STATUS_APPROX,
				center_x: c2_q.det.pos.x, center_y: c2_q.det.pos.y,
				center_z: c2_q.det.pos.z, out_norm_x: c2_q.det.nrm.x,
				out_norm_y: c2_q.det.nrm.y, out_norm_z: c2_q.det.nrm.z,
				standoff: '0};
		end
	end

`ifndef NO_ASSERTIONS
	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= CW'(MAX_DETECTIONS))
		else $error("frame count beyond store depth");
	a_dist_expected: assert property (@(posedge clk) disable iff (!arst_n)
		dist_done |-> (state_q == S_DVEH || state_q == S_DTGT || state_q == S_BALL_END
			|| state_q == S_WALK_WAIT || state_q == S_BALL_TICK))
		else $error("distance result arrived in a state that ignores it");
	a_walk_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> !ram_we)
		else $error("store written during a walk");
	a_track_needs_target: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(track_q) |-> tv_q)
		else $error("track mode entered without a target");
`endif

endmodule

// ===== design/nearest_target_tracker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_target_tracker_unit
// Two-mode nearest target tracker for 3D detections.
// ----------------------------------------------------------------------------
// Items enter a two-beat input queue and are executed one at a time by the
// engine behind it, which shares one two-stage squared-distance unit. A
// detection takes two distance passes, and a closing detection may add a
// sensing ball check. A search mode tick walks the frame store through its
// single read port, one stored detection after another. Reports wait in
// a two-beat result queue, so the engine stalls only when it is full.
// ----------------------------------------------------------------------------
module nearest_target_tracker_unit
	import ntt_pkg::*;
#(
	parameter int MAX_DETECTIONS        = MAX_DETECTIONS_DEF,
	parameter int TICK_SEARCH_RADIUS_MM = TICK_SEARCH_RADIUS_MM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   result,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [19:0] wr_data
);

	cfg_t      cfg_q;
	in_item_t  q_head;
	logic      q_empty, q_pop;
	out_item_t res;
	logic      out_full, out_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.standoff_mm    <= 19'd500;
			cfg_q.capture_margin <= 19'd1000;
			cfg_q.id_radius      <= 19'd500;
			cfg_q.sensing_radius <= 19'd1000;
			cfg_q.ball           <= '0;
			cfg_q.lost_ticks     <= 16'd10;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_STANDOFF_MM:    cfg_q.standoff_mm    <= wr_data[18:0];
				REG_CAPTURE_MARGIN: cfg_q.capture_margin <= wr_data[18:0];
				REG_ID_RADIUS:      cfg_q.id_radius      <= wr_data[18:0];
				REG_SENSING_RADIUS: cfg_q.sensing_radius <= wr_data[18:0];
				REG_BALL_X:         cfg_q.ball.x         <= wr_data;
				REG_BALL_Y:         cfg_q.ball.y         <= wr_data;
				REG_BALL_Z:         cfg_q.ball.z         <= wr_data;
				REG_LOST_TICKS:     cfg_q.lost_ticks     <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	ntt_fifo #(.W($bits(in_item_t)), .DEPTH(QUEUE_DEPTH)) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (item),
		.full   (full),
		.pop    (q_pop),
		.rdata  (q_head),
		.empty  (q_empty)
	);

	ntt_back #(
		.MAX_DETECTIONS        (MAX_DETECTIONS),
		.TICK_SEARCH_RADIUS_MM (TICK_SEARCH_RADIUS_MM)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_head   (q_head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.res      (res),
		.out_full (out_full),
		.out_push (out_push)
	);

	ntt_fifo #(.W($bits(out_item_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

// ===== dv/tb_nearest_target_tracker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_target_tracker_unit
// Self-checking bench for the nearest target tracker.
// ----------------------------------------------------------------------------
// A short table of directed items, some with the report written out by hand,
// is followed by random scenes around the sensing ball under several register
// settings. Each accepted item runs through a behavioral tracker in the bench.
// Each report it predicts waits in a queue and is compared field by field with
// the result beat that the block hands out. Both sides idle at random, and
// once the receiver holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_nearest_target_tracker_unit;
	import ntt_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		bit                valid;
		longint unsigned   d2;
		longint            p[3];
		logic [15:0]       n[3];
	} track_cand_t;

	typedef struct {
		in_item_t  it;
		bit        has_report;
		out_item_t report;
	} table_row_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_item_t    item;
	logic        empty;
	logic        pop;
	out_item_t   result;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [19:0] wr_data;

	out_item_t   report_q[$];
	table_row_t  rows[$];
	int          errors = 0;
	int          beats_seen = 0;
	int          stall_left = 0;
	bit          held = 1'b0;

	// Tracker state kept by the bench.
	longint unsigned cfg_td, cfg_cm, cfg_it, cfg_sr, cfg_lost;
	longint          cfg_ball[3];
	bit              trk_mode, tgt_valid, frm_open;
	longint          tgt_pos[3];
	logic [15:0]     tgt_dir[3];
	longint          veh_pos[3];
	longint unsigned since_refind;
	track_cand_t     near_vehicle, near_target, walk_best;
	longint          store_pos[32][3];
	logic [15:0]     store_nrm[32][3];
	int              store_count;

	nearest_target_tracker_unit DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#50ms;
		$display("tb: failure");
		$finish;
	end

	function automatic longint unsigned sq_dist(longint a[3], longint b[3]);
		longint unsigned s;
		longint d;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			d = a[i] - b[i];
			s += longint'(d * d);
		end
		return s;
	endfunction

	function automatic void offer(ref track_cand_t c, input longint unsigned d2,
			input longint p[3], input logic [15:0] n[3]);
		if (!c.valid || d2 < c.d2) begin
			c.valid = 1'b1;
			c.d2 = d2;
			c.p = p;
			c.n = n;
		end
	endfunction

	function automatic void take_target(track_cand_t c);
		tgt_pos = c.p;
		tgt_dir = c.n;
		tgt_valid = 1'b1;
		since_refind = 0;
	endfunction

	function automatic out_item_t make_report(logic [1:0] st, longint p[3],
			logic [15:0] n[3], longint unsigned so);
		out_item_t o;
		o.status = st;
		o.center_x = 20'(p[0]);
		o.center_y = 20'(p[1]);
		o.center_z = 20'(p[2]);
		o.out_norm_x = n[0];
		o.out_norm_y = n[1];
		o.out_norm_z = n[2];
		o.standoff = 19'(so);
		return o;
	endfunction

	function automatic bit track_step(in_item_t it, output out_item_t o);
		longint          p[3];
		logic [15:0]     n[3];
		longint          zp[3];
		logic [15:0]     zn[3];
		longint unsigned cap;
		p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
		n = '{it.norm_x, it.norm_y, it.norm_z};
		zp = '{0, 0, 0};
		zn = '{16'd0, 16'd0, 16'd0};
		o = '0;
		case (it.action)
			ACT_VEHICLE: begin
				veh_pos = p;
			end
			ACT_DETECT: begin
				if (!frm_open) begin
					store_count = 0;
					near_vehicle.valid = 1'b0;
					near_target.valid = 1'b0;
					frm_open = 1'b1;
				end
				if (store_count < 32) begin
					store_pos[store_count] = p;
					store_nrm[store_count] = n;
					store_count++;
				end
				offer(near_vehicle, sq_dist(p, veh_pos), p, n);
				offer(near_target, sq_dist(p, tgt_pos), p, n);
				if (it.frame_last) begin
					frm_open = 1'b0;
					if (!trk_mode) begin
						cap = cfg_td + cfg_cm;
						if (near_vehicle.valid && near_vehicle.d2 < cap * cap) begin
							take_target(near_vehicle);
							if (sq_dist(tgt_pos, cfg_ball) < cfg_sr * cfg_sr)
								trk_mode = 1'b1;
						end else begin
							tgt_valid = 1'b0;
						end
					end else if (!tgt_valid) begin
						trk_mode = 1'b0;
					end else if (near_target.valid &&
							near_target.d2 < cfg_it * cfg_it) begin
						take_target(near_target);
					end
				end
			end
			ACT_TICK: begin
				if (trk_mode) begin
					if (since_refind < 65535)
						since_refind++;
					if (since_refind > cfg_lost) begin
						trk_mode = 1'b0;
						o = make_report(STATUS_LOST, zp, zn, 0);
						return 1'b1;
					end
					if (!tgt_valid) begin
						trk_mode = 1'b0;
						return 1'b0;
					end
					o = make_report(STATUS_CAPTURED, tgt_pos, tgt_dir, cfg_td);
					return 1'b1;
				end
				walk_best.valid = 1'b0;
				for (int i = 0; i < store_count; i++)
					offer(walk_best, sq_dist(store_pos[i], veh_pos), store_pos[i],
						store_nrm[i]);
				if (walk_best.valid &&
						walk_best.d2 < longint'(TICK_SEARCH_RADIUS_MM_DEF) *
						longint'(TICK_SEARCH_RADIUS_MM_DEF)) begin
					since_refind = 0;
					if (sq_dist(walk_best.p, cfg_ball) < cfg_sr * cfg_sr) begin
						o = make_report(STATUS_APPROX, walk_best.p, walk_best.n, 0);
						return 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		return 1'b0;
	endfunction

	task automatic send(in_item_t it, bit has_report, out_item_t typed);
		out_item_t o;
		int        gap;
		int        r;
		item <= it;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		if (track_step(it, o))
			report_q.insert(report_q.size(), has_report ? typed : o);
		r = $urandom_range(0, 99);
		gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [19:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			REG_STANDOFF_MM:    cfg_td = val[18:0];
			REG_CAPTURE_MARGIN: cfg_cm = val[18:0];
			REG_ID_RADIUS:      cfg_it = val[18:0];
			REG_SENSING_RADIUS: cfg_sr = val[18:0];
			REG_BALL_X:         cfg_ball[0] = longint'($signed(val));
			REG_BALL_Y:         cfg_ball[1] = longint'($signed(val));
			REG_BALL_Z:         cfg_ball[2] = longint'($signed(val));
			default:            cfg_lost = val[15:0];
		endcase
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	function automatic in_item_t make_item(logic [1:0] act, longint x, longint y,
			longint z, bit last);
		in_item_t it;
		it.action = act;
		it.pos_x = 20'(x);
		it.pos_y = 20'(y);
		it.pos_z = 20'(z);
		it.norm_x = 16'($urandom_range(0, 32768) - 16384);
		it.norm_y = 16'($urandom_range(0, 32768) - 16384);
		it.norm_z = 16'($urandom_range(0, 32768) - 16384);
		it.frame_last = last;
		return it;
	endfunction

	function automatic longint near_coord(longint c, int spread);
		longint v;
		v = c + longint'($urandom_range(0, 2 * spread)) - spread;
		if (v > 524287)
			v = 524287;
		if (v < -524288)
			v = -524288;
		return v;
	endfunction

	function automatic in_item_t near_item(logic [1:0] act, int spread, bit last);
		return make_item(act, near_coord(cfg_ball[0], spread),
			near_coord(cfg_ball[1], spread), near_coord(cfg_ball[2], spread), last);
	endfunction

	always @(posedge clk) begin
		if (pop && !empty) begin
			beats_seen++;
			if (report_q.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				out_item_t e;
				e = report_q.pop_front();
				if (result.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, result.status);
					errors++;
				end
				if (result.center_x !== e.center_x) begin
					$error("center_x: expected %0d, got %0d", e.center_x, result.center_x);
					errors++;
				end
				if (result.center_y !== e.center_y) begin
					$error("center_y: expected %0d, got %0d", e.center_y, result.center_y);
					errors++;
				end
				if (result.center_z !== e.center_z) begin
					$error("center_z: expected %0d, got %0d", e.center_z, result.center_z);
					errors++;
				end
				if (result.out_norm_x !== e.out_norm_x) begin
					$error("out_norm_x: expected %0d, got %0d", e.out_norm_x,
						result.out_norm_x);
					errors++;
				end
				if (result.out_norm_y !== e.out_norm_y) begin
					$error("out_norm_y: expected %0d, got %0d", e.out_norm_y,
						result.out_norm_y);
					errors++;
				end
				if (result.out_norm_z !== e.out_norm_z) begin
					$error("out_norm_z: expected %0d, got %0d", e.out_norm_z,
						result.out_norm_z);
					errors++;
				end
				if (result.standoff !== e.standoff) begin
					$error("standoff: expected %0d, got %0d", e.standoff, result.standoff);
					errors++;
				end
			end
		end
		if (arst_n) begin
			if (beats_seen >= 40 && !held) begin
				held = 1'b1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				int r;
				r = $urandom_range(0, 99);
				stall_left = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) :
					$urandom_range(8, 40);
				pop <= (stall_left == 0);
			end
		end else begin
			pop <= 1'b0;
		end
	end

	initial begin
		out_item_t  none;
		in_item_t   it;
		longint     p100[3];
		longint     zp[3];
		logic [15:0] nd[3];
		logic [15:0] zn[3];
		int         r;
		int         len;
		int         sent;
		int         spread;

		none = '0;
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		wr_en <= 1'b0;
		wr_index <= REG_STANDOFF_MM;
		wr_data <= '0;

		cfg_td = 500;
		cfg_cm = 1000;
		cfg_it = 500;
		cfg_sr = 1000;
		cfg_ball = '{0, 0, 0};
		cfg_lost = 10;
		trk_mode = 1'b0;
		tgt_valid = 1'b0;
		frm_open = 1'b0;
		tgt_pos = '{0, 0, 0};
		tgt_dir = '{16'd0, 16'd0, 16'd0};
		veh_pos = '{0, 0, 0};
		since_refind = 0;
		near_vehicle.valid = 1'b0;
		near_target.valid = 1'b0;
		walk_best.valid = 1'b0;
		store_count = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table under the reset register values.
		p100 = '{100, 0, 0};
		zp = '{0, 0, 0};
		nd = '{16'sd16384, -16'sd16384, 16'd0};
		zn = '{16'd0, 16'd0, 16'd0};
		rows.insert(rows.size(), '{make_item(ACT_TICK, 0, 0, 0, 0), 0, none});
		rows.insert(rows.size(), '{make_item(ACT_VEHICLE, 0, 0, 0, 0), 0, none});
		it = make_item(ACT_DETECT, 100, 0, 0, 1);
		it.norm_x = nd[0];
		it.norm_y = nd[1];
		it.norm_z = nd[2];
		rows.insert(rows.size(), '{it, 0, none});
		rows.insert(rows.size(), '{make_item(ACT_TICK, 0, 0, 0, 0), 1,
			make_report(STATUS_CAPTURED, p100, nd, 500)});
		it = make_item(ACT_UNUSED, -1, -1, -1, 1);
		rows.insert(rows.size(), '{it, 0, none});
		rows.insert(rows.size(),
			'{make_item(ACT_DETECT, 524287, 524287, 524287, 0), 0, none});
		rows.insert(rows.size(),
			'{make_item(ACT_DETECT, -524288, -524288, -524288, 1), 0, none});
		rows.insert(rows.size(), '{make_item(ACT_TICK, 0, 0, 0, 0), 1,
			make_report(STATUS_CAPTURED, p100, nd, 500)});
		for (int i = 0; i < 8; i++)
			rows.insert(rows.size(), '{make_item(ACT_TICK, 0, 0, 0, 0), 0, none});
		rows.insert(rows.size(), '{make_item(ACT_TICK, 0, 0, 0, 0), 1,
			make_report(STATUS_LOST, zp, zn, 0)});
		rows.insert(rows.size(), '{make_item(ACT_TICK, 0, 0, 0, 0), 0, none});
		rows.insert(rows.size(),
			'{make_item(ACT_VEHICLE, 524287, 524287, 524287, 0), 0, none});
		rows.insert(rows.size(),
			'{make_item(ACT_DETECT, 524000, 524287, 524287, 0), 0, none});
		rows.insert(rows.size(), '{make_item(ACT_VEHICLE, 0, 0, 0, 0), 0, none});
		rows.insert(rows.size(), '{make_item(ACT_DETECT, 300, 0, 0, 0), 0, none});
		rows.insert(rows.size(), '{make_item(ACT_TICK, 0, 0, 0, 0), 0, none});
		rows.insert(rows.size(), '{make_item(ACT_DETECT, 200, 0, 0, 1), 0, none});
		rows.insert(rows.size(), '{make_item(ACT_TICK, 0, 0, 0, 0), 0, none});
		foreach (rows[i])
			send(rows[i].it, rows[i].has_report, rows[i].report);

		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				wait_idle();
				case (phase)
					1: begin
						write_reg(REG_STANDOFF_MM, 20'h7FFFF);
						write_reg(REG_CAPTURE_MARGIN, 20'h7FFFF);
						write_reg(REG_ID_RADIUS, 20'h7FFFF);
						write_reg(REG_SENSING_RADIUS, 20'h7FFFF);
						write_reg(REG_BALL_X, 20'h7FFFF);
						write_reg(REG_BALL_Y, 20'h7FFFF);
						write_reg(REG_BALL_Z, 20'h7FFFF);
						write_reg(REG_LOST_TICKS, 20'h0FFFF);
					end
					2: begin
						write_reg(REG_STANDOFF_MM, 20'd0);
						write_reg(REG_CAPTURE_MARGIN, 20'd0);
						write_reg(REG_ID_RADIUS, 20'd0);
						write_reg(REG_SENSING_RADIUS, 20'd0);
						write_reg(REG_BALL_X, 20'h80000);
						write_reg(REG_BALL_Y, 20'h80000);
						write_reg(REG_BALL_Z, 20'h80000);
						write_reg(REG_LOST_TICKS, 20'd0);
					end
					default: begin
						write_reg(REG_STANDOFF_MM, 20'($urandom_range(0, 3000)));
						write_reg(REG_CAPTURE_MARGIN, 20'($urandom_range(0, 3000)));
						write_reg(REG_ID_RADIUS, 20'($urandom_range(0, 2000)));
						write_reg(REG_SENSING_RADIUS, 20'($urandom_range(0, 5000)));
						write_reg(REG_BALL_X, 20'($urandom));
						write_reg(REG_BALL_Y, 20'($urandom));
						write_reg(REG_BALL_Z, 20'($urandom));
						write_reg(REG_LOST_TICKS, 20'($urandom_range(0, 20)));
					end
				endcase
				wr_en <= 1'b0;
			end
			sent = 0;
			while (sent < 230) begin
				r = $urandom_range(0, 99);
				spread = (r % 3 == 0) ? 200 : (r % 3 == 1) ? 1500 : 6000;
				if (r < 8) begin
					it = make_item(2'($urandom_range(0, 3)), 0, 0, 0,
						1'($urandom_range(0, 1)));
					it.pos_x = 20'($urandom);
					it.pos_y = 20'($urandom);
					it.pos_z = 20'($urandom);
					send(it, 0, none);
					sent++;
				end else if (r < 20) begin
					send(near_item(ACT_VEHICLE, spread, 0), 0, none);
					sent++;
				end else if (r < 38) begin
					send(near_item(ACT_TICK, spread, 0), 0, none);
					sent++;
				end else begin
					len = ($urandom_range(0, 99) < 4) ? $urandom_range(33, 36) :
						$urandom_range(1, 6);
					for (int k = 0; k < len; k++)
						send(near_item(ACT_DETECT, spread,
							(k == len - 1) && ($urandom_range(0, 9) != 0)), 0, none);
					sent += len;
				end
			end
		end

		push <= 1'b0;
		@(posedge clk);
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && report_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/ntt_pkg.sv
design/ntt_ram.sv
design/ntt_fifo.sv
design/ntt_dist.sv
design/ntt_back.sv
design/nearest_target_tracker_unit.sv
dv/tb_nearest_target_tracker_unit.sv
